// ===== src/sdcf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdcf_pkg - shared types and constants for the suffixed decimal count finder
// Byte codes of the pattern, scan phases and the result record.
// ----------------------------------------------------------------------------
package sdcf_pkg;

  localparam int unsigned ValueBitsDefault = 32;
  localparam int unsigned OutValueBits     = 32;
  localparam int unsigned RegAddrBits      = 3;
  localparam int unsigned RegDataBits      = 32;

  // register index (paddr[2]) of min_run_length
  localparam logic RegMinRunIdx = 1'b0;

  localparam logic [3:0] MinRunReset = 4'd2;
  localparam logic [3:0] CountMax    = 4'hF;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] MarkByte0 = 8'hE4;
  localparam logic [7:0] MarkByte1 = 8'hBB;
  localparam logic [7:0] MarkByte2 = 8'hB6;

  typedef enum logic [2:0] {
    PhIdle,
    PhRun,
    PhSpace,
    PhMark1,
    PhMark2
  } phase_e;

  typedef struct packed {
    logic                    found;
    logic [OutValueBits-1:0] listing_count;
    logic                    saturated;
  } result_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CharZero) && (b <= CharNine);
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == CharSpace) || ((b >= CharTab) && (b <= CharCr));
  endfunction

endpackage

// ===== src/sdcf_scan.sv =====
// ----------------------------------------------------------------------------
// sdcf_scan - per-byte pattern scanner
// Holds the scan state; one byte is folded in on each accepted transfer.
// ----------------------------------------------------------------------------
module sdcf_scan #(
  parameter int unsigned ValueBits = sdcf_pkg::ValueBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       text_byte_i,
  input  logic             message_end_i,
  input  logic [3:0]       min_run_length_i,
  output logic             result_valid_o,
  output sdcf_pkg::result_t result_o
);
  import sdcf_pkg::*;

  localparam int unsigned ProdBits = ValueBits + 4;

  phase_e               phase_q, phase_d;
  logic [ValueBits-1:0] acc_q, acc_d;
  logic                 ovf_q, ovf_d;
  logic [3:0]           cnt_q, cnt_d;
  logic                 match_q, match_d;
  logic [ValueBits-1:0] mval_q, mval_d;
  logic                 msat_q, msat_d;

  logic                 digit;
  logic [3:0]           dval;
  logic [ProdBits-1:0]  prod;
  logic                 add_ovf;
  logic [ValueBits-1:0] add_acc;
  logic [3:0]           cnt_bump;
  logic                 fail;
  logic                 hit;

  // acc * 10 + d; anything above ValueBits means overflow
  assign digit    = is_digit(text_byte_i);
  assign dval     = text_byte_i[3:0];
  assign prod     = (ProdBits'(acc_q) << 3) + (ProdBits'(acc_q) << 1) + ProdBits'(dval);
  assign add_ovf  = ovf_q || (prod[ProdBits-1 -: 4] != 4'd0);
  assign add_acc  = add_ovf ? '1 : prod[ValueBits-1:0];
  assign cnt_bump = (cnt_q == CountMax) ? cnt_q : cnt_q + 4'd1;

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    cnt_d    = cnt_q;
    match_d  = match_q;
    mval_d   = mval_q;
    msat_d   = msat_q;
    fail     = 1'b0;
    hit      = 1'b0;

    if (!match_q) begin
      unique case (phase_q)
        PhRun: begin
          priority if (digit) begin
            acc_d = add_acc;
            ovf_d = add_ovf;
            cnt_d = cnt_bump;
          end else if (text_byte_i == CharComma) begin
            cnt_d = cnt_bump;
          end else if (is_space(text_byte_i)) begin
            phase_d = PhSpace;
          end else if (text_byte_i == MarkByte0) begin
            phase_d = PhMark1;
          end else begin
            fail = 1'b1;
          end
        end
        PhSpace: begin
          priority if (is_space(text_byte_i)) begin
            phase_d = PhSpace;
          end else if (text_byte_i == MarkByte0) begin
            phase_d = PhMark1;
          end else begin
            fail = 1'b1;
          end
        end
        PhMark1: begin
          if (text_byte_i == MarkByte1) begin
            phase_d = PhMark2;
          end else begin
            fail = 1'b1;
          end
        end
        PhMark2: begin
          if ((text_byte_i == MarkByte2) && (cnt_q >= min_run_length_i)) begin
            hit = 1'b1;
          end else begin
            fail = 1'b1;
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase
    end

    if (hit) begin
      match_d = 1'b1;
      mval_d  = acc_q;
      msat_d  = ovf_q;
      phase_d = PhIdle;
      acc_d   = '0;
      ovf_d   = 1'b0;
      cnt_d   = 4'd0;
    end

    // failing byte is looked at again as if idle
    if (fail) begin
      if (digit) begin
        phase_d = PhRun;
        acc_d   = ValueBits'(dval);
        ovf_d   = 1'b0;
        cnt_d   = 4'd1;
      end else begin
        phase_d = PhIdle;
        acc_d   = '0;
        ovf_d   = 1'b0;
        cnt_d   = 4'd0;
      end
    end

    result_valid_o          = step_i && message_end_i;
    result_o.found          = match_d;
    result_o.listing_count  = match_d ? OutValueBits'(mval_d) : '0;
    result_o.saturated      = match_d && msat_d;

    if (message_end_i) begin
      phase_d = PhIdle;
      acc_d   = '0;
      ovf_d   = 1'b0;
      cnt_d   = 4'd0;
      match_d = 1'b0;
      mval_d  = '0;
      msat_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      cnt_q   <= 4'd0;
      match_q <= 1'b0;
      mval_q  <= '0;
      msat_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
      match_q <= match_d;
      mval_q  <= mval_d;
      msat_q  <= msat_d;
    end
  end

endmodule

// ===== src/suffixed_decimal_count_finder.sv =====
// ----------------------------------------------------------------------------
// suffixed_decimal_count_finder - finds the first digit run tagged E4 BB B6
// Streams message bytes in, returns one result per message.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: one message byte per transfer in s_axis_tdata[7:0],
//    s_axis_tlast on the final byte of the message.
//  - Master stream: one transfer per message, issued for the tlast byte.
//    m_axis_tdata = listing_count, m_axis_tuser = {value_saturated,
//    count_found}. No match gives found = 0 and a zero count.
//  - APB: min_run_length at byte address 0 (4 bits, reset 2).
//  - Throughput: one byte per clock while s_axis_tready is high. The scanner
//    state update is a single step of combinational logic (a x10 + digit add, compares).
//  - Output: the result for the tlast byte is registered before it shows on m_axis.
//  - Stall: a two-entry output stage (output register plus skid) lets the
//    block keep taking bytes while a result waits; s_axis_tready drops only
//    once both entries hold results.
//  - Reset: scan state cleared, register back to 2, output stage empty.
// ----------------------------------------------------------------------------
module suffixed_decimal_count_finder #(
  parameter int unsigned VALUE_BITS = sdcf_pkg::ValueBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] text_byte
  input  logic                              s_axis_tlast,  // message_end
  // master stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sdcf_pkg::OutValueBits-1:0] m_axis_tdata,  // [31:0] listing_count
  output logic [1:0]                        m_axis_tuser,  // [0] count_found,
                                                           // [1] value_saturated
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sdcf_pkg::RegAddrBits-1:0]  paddr,
  input  logic [sdcf_pkg::RegDataBits-1:0]  pwdata,
  output logic [sdcf_pkg::RegDataBits-1:0]  prdata,
  output logic                              pready
);
  import sdcf_pkg::*;

  logic [3:0] min_run_q;
  logic       reg_wr;

  logic       step;
  logic       res_valid;
  result_t    res;

  logic       out_valid_q, out_valid_d;
  result_t    out_q, out_d;
  logic       skid_valid_q, skid_valid_d;
  result_t    skid_q, skid_d;
  logic       pop;

  // ---- config register ----
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[2] == RegMinRunIdx);
  assign prdata = (paddr[2] == RegMinRunIdx) ? RegDataBits'(min_run_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_run_q <= MinRunReset;
    end else if (reg_wr) begin
      min_run_q <= pwdata[3:0];
    end
  end

  // ---- scanner ----
  assign s_axis_tready = !skid_valid_q;
  assign step          = s_axis_tvalid && s_axis_tready;

  sdcf_scan #(
    .ValueBits (VALUE_BITS)
  ) u_scan (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .text_byte_i      (s_axis_tdata),
    .message_end_i    (s_axis_tlast),
    .min_run_length_i (min_run_q),
    .result_valid_o   (res_valid),
    .result_o         (res)
  );

  // ---- output register + skid ----
  assign pop = out_valid_q && m_axis_tready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (res_valid) begin
        out_d        = res;
        out_valid_d  = 1'b1;
      end else begin
        out_valid_d  = 1'b0;
      end
    end else if (res_valid) begin
      // output held by the receiver, park the new result
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.listing_count;
  assign m_axis_tuser  = {out_q.saturated, out_q.found};

endmodule

// ===== src/sdcf_checker.sv =====
// ----------------------------------------------------------------------------
// sdcf_checker - port-level checks for the suffixed decimal count finder
// Watches the stream ports; bound to the top level below.
// ----------------------------------------------------------------------------
module sdcf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              s_axis_tlast,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [sdcf_pkg::OutValueBits-1:0] m_axis_tdata,
  input logic [1:0]                        m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // no match: count and saturation are zero
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
    else $error("non-zero result without a match");

  // a result only follows a final byte
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("result without a message end");

  // input backpressure only when results are waiting
  a_ready_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

endmodule

bind suffixed_decimal_count_finder sdcf_checker u_sdcf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/tb_suffixed_decimal_count_finder.sv =====
// ----------------------------------------------------------------------------
// tb_suffixed_decimal_count_finder - self-checking bench for the count finder
// Streams text messages into the block. A scoreboard predicts the per-message
// result (found flag, decoded count, saturation flag) and checks each transfer
// on the master stream. min_run_length is swept over several values via APB.
// ----------------------------------------------------------------------------
module tb_suffixed_decimal_count_finder;
  timeunit 1ns;
  timeprecision 1ps;

  import sdcf_pkg::*;

  typedef logic [7:0] octet_t;

  // byte address of min_run_length on the APB port
  localparam logic [RegAddrBits-1:0] MinRunAddr = {RegMinRunIdx, 2'b00};
  localparam int unsigned PhaseBytes = 105;  // minimum stream bytes per register setting
  localparam int unsigned SettleCycles = 4;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the scanner plus a queue of pending results
  // --------------------------------------------------------------------------
  class listing_scoreboard;
    logic [3:0]  min_run;
    phase_e      phase;
    logic [63:0] acc;
    logic        ovf;
    logic [3:0]  run_len;
    logic        latched;
    logic [31:0] hit_value;
    logic        hit_sat;
    result_t     expected_q[$];
    int unsigned errors, n_bytes, n_msgs, n_found, n_sat;

    function new();
      min_run = MinRunReset;
      latched = 1'b0;
      hit_value = '0;
      hit_sat = 1'b0;
      errors = 0;
      n_bytes = 0;
      n_msgs = 0;
      n_found = 0;
      n_sat = 0;
      restart();
    endfunction

    function void set_min_run(logic [3:0] v);
      min_run = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function bit numeral(octet_t b);
      return b >= CharZero && b <= CharNine;
    endfunction

    function bit blank(octet_t b);
      return b == CharSpace || (b >= CharTab && b <= CharCr);
    endfunction

    function void restart();
      phase = PhIdle;
      acc = '0;
      ovf = 1'b0;
      run_len = '0;
    endfunction

    // x10 + digit, clamped to 32 bits once it would overflow
    function void accumulate(octet_t b);
      logic [63:0] d;
      logic [63:0] lim;
      d = 64'(b - CharZero);
      lim = 64'hFFFF_FFFF;
      if (ovf || acc > (lim - d) / 10) begin
        acc = lim;
        ovf = 1'b1;
      end else begin
        acc = acc * 10 + d;
      end
      if (run_len != CountMax) run_len++;
    endfunction

    function void scan(octet_t b);
      case (phase)
        PhRun: begin
          if (numeral(b)) begin
            accumulate(b);
            return;
          end
          if (b == CharComma) begin
            if (run_len != CountMax) run_len++;
            return;
          end
          if (blank(b)) begin
            phase = PhSpace;
            return;
          end
          if (b == MarkByte0) begin
            phase = PhMark1;
            return;
          end
        end
        PhSpace: begin
          if (blank(b)) return;
          if (b == MarkByte0) begin
            phase = PhMark1;
            return;
          end
        end
        PhMark1: begin
          if (b == MarkByte1) begin
            phase = PhMark2;
            return;
          end
        end
        PhMark2: begin
          if (b == MarkByte2 && run_len >= min_run) begin
            latched = 1'b1;
            hit_value = acc[31:0];
            hit_sat = ovf;
            restart();
            return;
          end
        end
        default: ;
      endcase
      // broken candidate: the failing byte is looked at again from idle
      restart();
      if (numeral(b)) begin
        accumulate(b);
        phase = PhRun;
      end
    endfunction

    // called for every accepted slave-side transfer
    function void note_byte(octet_t b, logic last);
      result_t r;
      n_bytes++;
      if (!latched) scan(b);
      if (last) begin
        r.found = latched;
        r.listing_count = latched ? hit_value : '0;
        r.saturated = latched && hit_sat;
        expected_q.push_back(r);
        restart();
        latched = 1'b0;
        hit_value = '0;
        hit_sat = 1'b0;
      end
    endfunction

    // called for every accepted master-side transfer
    function void check_result(logic [31:0] count, logic [1:0] flags);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: listing_count=%0d tuser=%b", count, flags);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      n_msgs++;
      if (want.found) n_found++;
      if (want.saturated) n_sat++;
      if (flags[0] !== want.found) begin
        $error("count_found: expected %0b, got %0b", want.found, flags[0]);
        errors++;
      end
      if (count !== want.listing_count) begin
        $error("listing_count: expected %0d, got %0d", want.listing_count, count);
        errors++;
      end
      if (flags[1] !== want.saturated) begin
        $error("value_saturated: expected %0b, got %0b", want.saturated, flags[1]);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;   // [7:0] text_byte
  logic                   s_axis_tlast;   // message_end
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OutValueBits-1:0] m_axis_tdata;  // [31:0] listing_count
  logic [1:0]             m_axis_tuser;   // [0] count_found, [1] value_saturated
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [RegAddrBits-1:0] paddr;
  logic [RegDataBits-1:0] pwdata;
  logic [RegDataBits-1:0] prdata;
  logic                   pready;

  suffixed_decimal_count_finder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  listing_scoreboard sb;
  octet_t            msg_q[$];       // message under construction
  int unsigned       burst_left;     // transfers left before the next sender gap
  int unsigned       ready_mode;
  int unsigned       ready_hold;
  int unsigned       cfg_errors;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the handshake hangs somewhere.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Monitors: both stream sides sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Receiver backpressure: a random mode is picked whenever ready_hold runs out. Mode 0 never
  // stalls, mode 2 stalls hard enough to fill the output stage and push back
  // onto the slave side.
  always @(negedge clk_i) begin
    if (ready_hold == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_hold = $urandom_range(16, 80);
    end
    ready_hold--;
    case (ready_mode)
      0:       m_axis_tready = 1'b1;
      1:       m_axis_tready = 1'($urandom_range(0, 1));
      2:       m_axis_tready = ($urandom_range(0, 7) == 0);
      default: m_axis_tready = ($urandom_range(0, 3) != 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Driver tasks (all entered and left at a falling edge)
  // --------------------------------------------------------------------------
  task automatic cfg_write(input logic [3:0] v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = MinRunAddr;
    pwdata = 32'(v);
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    sb.set_min_run(v);
  endtask

  task automatic cfg_readback(input logic [3:0] v);
    logic [RegDataBits-1:0] rd;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = MinRunAddr;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    if (rd[3:0] !== v) begin
      $error("min_run_length readback: expected %0d, got %0d", v, rd[3:0]);
      cfg_errors++;
    end
  endtask

  // One transfer on the slave side. tvalid stays high into the next byte
  // unless the burst runs out, so back-to-back transfers happen too.
  task automatic push_byte(input octet_t b, input logic last);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tlast = last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_message();
    foreach (msg_q[i]) push_byte(msg_q[i], i == msg_q.size() - 1);
    msg_q.delete();
  endtask

  // Hold the sender until every predicted result has been seen, then let
  // the block settle.
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Message builders
  // --------------------------------------------------------------------------
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endfunction

  function automatic octet_t blank_byte();
    int unsigned v;
    v = $urandom_range(8, 13);
    return (v == 8) ? CharSpace : octet_t'(v);
  endfunction

  // Bytes biased toward the ones the scanner cares about.
  function automatic octet_t noise_byte();
    case ($urandom_range(0, 6))
      0: return CharZero + octet_t'($urandom_range(0, 9));
      1: return CharComma;
      2: return blank_byte();
      3: return MarkByte0;
      4: return ($urandom_range(0, 1) != 0) ? MarkByte1 : MarkByte2;
      5: return 8'h00;
      default: return octet_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Prefix, digit/comma run, optional blanks, marker (sometimes broken),
  // then a tail that may hold a second listing which must be ignored.
  function automatic void build_listing(int unsigned min_run);
    int unsigned len;
    int unsigned kind;
    int unsigned bad_pos;
    octet_t b;
    repeat ($urandom_range(0, 4)) begin
      b = octet_t'($urandom_range(0, 255));
      if (b >= CharZero && b <= CharNine) b = b ^ 8'h40;
      msg_q.push_back(b);
    end
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      add_text("4294967295");
    end else if (kind == 1) begin
      add_text("4294967296");
    end else begin
      case (kind)
        2, 3:    len = (min_run + $urandom_range(0, 2) > 1) ? min_run + $urandom_range(0, 2) - 1 : 1;
        4, 5:    len = $urandom_range(1, 4);
        6, 7:    len = $urandom_range(5, 12);
        default: len = $urandom_range(13, 20);
      endcase
      msg_q.push_back(CharZero + octet_t'($urandom_range(0, 9)));
      for (int i = 1; i < len; i++) begin
        if ($urandom_range(0, 4) == 0) msg_q.push_back(CharComma);
        else msg_q.push_back(CharZero + octet_t'($urandom_range(0, 9)));
      end
    end
    repeat ($urandom_range(0, 2)) msg_q.push_back(blank_byte());
    bad_pos = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2) : 3;
    msg_q.push_back(bad_pos == 0 ? noise_byte() : MarkByte0);
    msg_q.push_back(bad_pos == 1 ? noise_byte() : MarkByte1);
    msg_q.push_back(bad_pos == 2 ? noise_byte() : MarkByte2);
    case ($urandom_range(0, 3))
      1: repeat ($urandom_range(1, 3)) msg_q.push_back(noise_byte());
      2: begin
        msg_q.push_back(CharZero + octet_t'($urandom_range(0, 9)));
        msg_q.push_back(CharZero + octet_t'($urandom_range(0, 9)));
        msg_q.push_back(MarkByte0);
        msg_q.push_back(MarkByte1);
        msg_q.push_back(MarkByte2);
      end
      default: ;
    endcase
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(1, 10)) msg_q.push_back(noise_byte());
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned setting[5];
    int unsigned sent_before;

    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    burst_left = 0;
    ready_hold = 0;
    ready_mode = 0;
    cfg_errors = 0;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed messages, register at its reset value of 2.
    // Match with a blank before the marker.
    add_text("30");
    msg_q.push_back(CharSpace);
    msg_q.push_back(MarkByte0);
    msg_q.push_back(MarkByte1);
    msg_q.push_back(MarkByte2);
    send_message();
    // Run too short; message ends on a zero byte.
    add_text("7");
    msg_q.push_back(MarkByte0);
    msg_q.push_back(MarkByte1);
    msg_q.push_back(MarkByte2);
    msg_q.push_back(8'h00);
    send_message();
    // Candidate breaks on a digit after E4, which then starts a new run.
    add_text("9");
    msg_q.push_back(MarkByte0);
    add_text("88");
    msg_q.push_back(MarkByte0);
    msg_q.push_back(MarkByte1);
    msg_q.push_back(MarkByte2);
    send_message();
    // Single all-ones byte, no match.
    msg_q.push_back(8'hFF);
    send_message();
    // Message ends inside a candidate.
    add_text("12");
    msg_q.push_back(MarkByte0);
    msg_q.push_back(MarkByte1);
    send_message();

    // Random part: one phase per register setting, extremes included.
    setting[0] = 1;
    setting[1] = 15;
    setting[2] = $urandom_range(3, 14);
    setting[3] = 2;
    setting[4] = $urandom_range(1, 15);
    foreach (setting[p]) begin
      wait_drained();
      cfg_write(4'(setting[p]));
      cfg_readback(4'(setting[p]));
      sent_before = sb.n_bytes;
      while (sb.n_bytes - sent_before < PhaseBytes) begin
        if ($urandom_range(0, 3) != 0) build_listing(setting[p]);
        else build_noise();
        send_message();
        // occasionally let the output side empty out completely
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
    end

    wait_drained();
    $display("covered %0d bytes in %0d messages: %0d matches, %0d clamped counts",
             sb.n_bytes, sb.n_msgs, sb.n_found, sb.n_sat);
    $display("min_run_length swept over 2, %0d, %0d, %0d, %0d, %0d",
             setting[0], setting[1], setting[2], setting[3], setting[4]);
    if (sb.errors == 0 && cfg_errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sdcf_pkg.sv
src/sdcf_scan.sv
src/suffixed_decimal_count_finder.sv
src/sdcf_checker.sv
verif/tb_suffixed_decimal_count_finder.sv
